// File: sv/vgu_pkg.sv
package vgu_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // magnitude of a difference of two components
  localparam int DIFF_W = COMP_WIDTH + 1;
  // root and radicand widths, radicand is a sum of three squares
  localparam int ROOT_W = COMP_WIDTH + 2;
  localparam int RAD_W  = 2 * ROOT_W;
  // signed product and signed dot sum
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int DOT_W  = 2 * COMP_WIDTH + 2;
  localparam int DMAG_W = 2 * COMP_WIDTH + 1;
  // divider: dividend, divisor, quotient, working remainder
  localparam int NUM_W  = 3 * COMP_WIDTH + 1;
  localparam int DEN_W  = RAD_W;
  localparam int QUO_W  = COMP_WIDTH + 1;
  localparam int REM_W  = DEN_W + QUO_W;

  typedef enum logic [2:0] {
    OP_DOT   = 3'd0,
    OP_CROSS = 3'd1,
    OP_MAG   = 3'd2,
    OP_NORM  = 3'd3,
    OP_DIST  = 3'd4,
    OP_PROJ  = 3'd5
  } op_e;

  // travels beside the root pipeline
  typedef struct packed {
    op_e                          op;
    logic [2:0][NUM_W-1:0]        num;
    logic [2:0]                   neg;
    logic [DEN_W-1:0]             den;
    logic                         zin;
    logic [3:0][COMP_WIDTH-1:0]   pre;
    logic                         pre_sat;
  } sq_side_t;

  // travels beside the divider pipeline
  typedef struct packed {
    op_e                          op;
    logic [2:0]                   neg;
    logic                         zin;
    logic [3:0][COMP_WIDTH-1:0]   pre;
    logic                         pre_sat;
  } dv_side_t;

  // clip a sign and magnitude value, returns {saturated flag, clipped value}
  function automatic logic [COMP_WIDTH:0] sat_val(input logic [NUM_W-1:0] mag,
                                                  input logic neg);
    logic [NUM_W-1:0]      lim;
    logic [COMP_WIDTH-1:0] m;
    logic                  s;
    lim = neg ? (NUM_W'(1) << (COMP_WIDTH - 1))
              : ((NUM_W'(1) << (COMP_WIDTH - 1)) - NUM_W'(1));
    if (mag > lim) begin
      m = lim[COMP_WIDTH-1:0];
      s = 1'b1;
    end else begin
      m = mag[COMP_WIDTH-1:0];
      s = 1'b0;
    end
    return {s, neg ? COMP_WIDTH'(-m) : m};
  endfunction

endpackage

// File: sv/vgu_sqrt.sv
module vgu_sqrt
  import vgu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  input  sq_side_t         side_i,
  output logic             valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sq_side_t         side_o
);

  localparam int TRIAL_W = RAD_W + 1;

  logic              vld_q  [ROOT_W];
  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] res_q  [ROOT_W];
  sq_side_t          side_q [ROOT_W];

  // one root bit per stage, most significant first
  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    localparam int K = ROOT_W - 1 - s;
    logic               vld_in;
    logic [RAD_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  res_in;
    sq_side_t           side_in;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign res_in  = res_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = (TRIAL_W'(res_in) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
    assign take  = TRIAL_W'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? RAD_W'(TRIAL_W'(rem_in) - trial) : rem_in;
        res_q[s]  <= take ? (res_in | (ROOT_W'(1) << K)) : res_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = res_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// File: sv/vgu_div.sv
module vgu_div
  import vgu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]      den_i,
  input  dv_side_t              side_i,
  output logic                  valid_o,
  output logic [2:0][QUO_W-1:0] quo_o,
  output dv_side_t              side_o
);

  logic                  vld_q  [QUO_W];
  logic [2:0][NUM_W-1:0] rem_q  [QUO_W];
  logic [2:0][QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0]      den_q  [QUO_W];
  dv_side_t              side_q [QUO_W];

  // three lanes share the divisor, one quotient bit per stage
  for (genvar s = 0; s < QUO_W; s++) begin : g_st
    localparam int K = QUO_W - 1 - s;
    logic                  vld_in;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [DEN_W-1:0]      den_in;
    dv_side_t              side_in;
    logic [REM_W-1:0]      shd;
    logic [2:0][NUM_W-1:0] rem_d;
    logic [2:0][QUO_W-1:0] quo_d;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign shd = REM_W'(den_in) << K;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (REM_W'(rem_in[l]) >= shd) begin
          rem_d[l] = NUM_W'(REM_W'(rem_in[l]) - shd);
          quo_d[l] = quo_in[l] | (QUO_W'(1) << K);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// File: sv/vector3_geometry_unit_core.sv
// stages from input transfer to result on the outputs
// (5 front stages, 34 root stages, 33 divider stages, 1 output register)
// throughput: one item per cycle, the whole pipeline advances together
// a stall on the output holds every stage in place
// reset: asynchronous, active low, clears all valid bits
module vector3_geometry_unit_core
  import vgu_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic signed [COMP_WIDTH-1:0] a_x_i,
  input  logic signed [COMP_WIDTH-1:0] a_y_i,
  input  logic signed [COMP_WIDTH-1:0] a_z_i,
  input  logic signed [COMP_WIDTH-1:0] b_x_i,
  input  logic signed [COMP_WIDTH-1:0] b_y_i,
  input  logic signed [COMP_WIDTH-1:0] b_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COMP_WIDTH-1:0] out_x_o,
  output logic signed [COMP_WIDTH-1:0] out_y_o,
  output logic signed [COMP_WIDTH-1:0] out_z_o,
  output logic signed [COMP_WIDTH-1:0] out_scalar_o,
  output logic                         saturated_o,
  output logic                         zero_input_o
);

  localparam int SQ_W = 2 * DIFF_W;

  logic adv;
  logic ov_q;
  assign adv        = !ov_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: operands and the magnitudes to be squared
  logic signed [COMP_WIDTH-1:0] ain [3];
  logic signed [COMP_WIDTH-1:0] bin [3];
  logic [DIFF_W-1:0]            sqm_d [3];
  assign ain[0] = a_x_i;
  assign ain[1] = a_y_i;
  assign ain[2] = a_z_i;
  assign bin[0] = b_x_i;
  assign bin[1] = b_y_i;
  assign bin[2] = b_z_i;

  always_comb begin
    logic signed [DIFF_W-1:0] dif;
    logic signed [DIFF_W-1:0] aex;
    for (int i = 0; i < 3; i++) begin
      dif = DIFF_W'(ain[i]) - DIFF_W'(bin[i]);
      aex = DIFF_W'(ain[i]);
      if (op_e'(req_type_i) == OP_DIST) begin
        sqm_d[i] = dif[DIFF_W-1] ? DIFF_W'(-dif) : DIFF_W'(dif);
      end else begin
        sqm_d[i] = aex[DIFF_W-1] ? DIFF_W'(-aex) : DIFF_W'(aex);
      end
    end
  end

  logic                         v1_q;
  logic [2:0]                   op1_q;
  logic signed [COMP_WIDTH-1:0] a1_q [3];
  logic signed [COMP_WIDTH-1:0] b1_q [3];
  logic [DIFF_W-1:0]            sqm1_q [3];

  // stage 2: products
  logic                         v2_q;
  logic [2:0]                   op2_q;
  logic signed [COMP_WIDTH-1:0] a2_q [3];
  logic signed [COMP_WIDTH-1:0] b2_q [3];
  logic signed [PROD_W-1:0]     dp2_q [3];
  logic signed [PROD_W-1:0]     cpa2_q [3];
  logic signed [PROD_W-1:0]     cpb2_q [3];
  logic [SQ_W-1:0]              sq2_q [3];
  logic [PROD_W-1:0]            bb2_q [3];

  // stage 3: sums
  logic                         v3_q;
  logic [2:0]                   op3_q;
  logic signed [COMP_WIDTH-1:0] a3_q [3];
  logic signed [COMP_WIDTH-1:0] b3_q [3];
  logic signed [DOT_W-1:0]      dot3_q;
  logic signed [PROD_W:0]       cr3_q [3];
  logic [RAD_W-1:0]             s3_q;
  logic [DEN_W-1:0]             u3_q;

  // stage 4: projection partial products, dot and cross results
  logic                         v4_q;
  logic [2:0]                   op4_q;
  logic [COMP_WIDTH-1:0]        aabs4_q [3];
  logic [PROD_W-1:0]            pl4_q [3];
  logic [PROD_W:0]              ph4_q [3];
  logic [2:0]                   neg4_q;
  logic                         zin4_q;
  logic [3:0][COMP_WIDTH-1:0]   pre4_q;
  logic                         psat4_q;
  logic [RAD_W-1:0]             s4_q;
  logic [DEN_W-1:0]             u4_q;

  // stage 5: dividends
  logic                         v5_q;
  logic [RAD_W-1:0]             s5_q;
  sq_side_t                     side5_q;

  logic [DMAG_W-1:0]            dabs;
  logic [COMP_WIDTH-1:0]        babs [3];
  logic [COMP_WIDTH-1:0]        aabs [3];
  logic [2:0]                   neg_d;
  logic                         zin_d;
  logic [3:0][COMP_WIDTH-1:0]   pre_d;
  logic                         psat_d;

  always_comb begin
    logic [COMP_WIDTH:0]   sv;
    logic [PROD_W:0]       cabs;
    dabs   = dot3_q[DOT_W-1] ? DMAG_W'(-dot3_q) : DMAG_W'(dot3_q);
    pre_d  = '0;
    psat_d = 1'b0;
    neg_d  = '0;
    sv     = '0;
    cabs   = '0;
    for (int i = 0; i < 3; i++) begin
      babs[i] = b3_q[i][COMP_WIDTH-1] ? COMP_WIDTH'(-b3_q[i]) : COMP_WIDTH'(b3_q[i]);
      aabs[i] = a3_q[i][COMP_WIDTH-1] ? COMP_WIDTH'(-a3_q[i]) : COMP_WIDTH'(a3_q[i]);
    end
    case (op_e'(op3_q))
      OP_DOT: begin
        sv       = sat_val(NUM_W'(dabs >> FRAC_BITS), dot3_q[DOT_W-1]);
        pre_d[3] = sv[COMP_WIDTH-1:0];
        psat_d   = sv[COMP_WIDTH];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          cabs     = cr3_q[i][PROD_W] ? (PROD_W + 1)'(-cr3_q[i]) : (PROD_W + 1)'(cr3_q[i]);
          sv       = sat_val(NUM_W'(cabs >> FRAC_BITS), cr3_q[i][PROD_W]);
          pre_d[i] = sv[COMP_WIDTH-1:0];
          psat_d   = psat_d | sv[COMP_WIDTH];
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) neg_d[i] = a3_q[i][COMP_WIDTH-1];
      end
      OP_PROJ: begin
        for (int i = 0; i < 3; i++) neg_d[i] = b3_q[i][COMP_WIDTH-1] ^ dot3_q[DOT_W-1];
      end
      default: begin
        psat_d = 1'b0;
      end
    endcase
    zin_d = (op_e'(op3_q) == OP_NORM && s3_q == '0) ||
            (op_e'(op3_q) == OP_PROJ && u3_q == '0);
  end

  sq_side_t side5_d;
  always_comb begin
    side5_d.op      = op_e'(op4_q);
    side5_d.neg     = neg4_q;
    side5_d.den     = u4_q;
    side5_d.zin     = zin4_q;
    side5_d.pre     = pre4_q;
    side5_d.pre_sat = psat4_q;
    for (int i = 0; i < 3; i++) begin
      if (op_e'(op4_q) == OP_NORM) begin
        side5_d.num[i] = NUM_W'(aabs4_q[i]) << FRAC_BITS;
      end else begin
        side5_d.num[i] = NUM_W'(pl4_q[i]) + (NUM_W'(ph4_q[i]) << COMP_WIDTH);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= req_type_i;
      op2_q <= op1_q;
      op3_q <= op2_q;
      op4_q <= op3_q;
      for (int i = 0; i < 3; i++) begin
        a1_q[i]   <= ain[i];
        b1_q[i]   <= bin[i];
        sqm1_q[i] <= sqm_d[i];
        a2_q[i]   <= a1_q[i];
        b2_q[i]   <= b1_q[i];
        dp2_q[i]  <= PROD_W'(a1_q[i]) * PROD_W'(b1_q[i]);
        sq2_q[i]  <= SQ_W'(sqm1_q[i]) * SQ_W'(sqm1_q[i]);
        bb2_q[i]  <= PROD_W'(PROD_W'(b1_q[i]) * PROD_W'(b1_q[i]));
        a3_q[i]   <= a2_q[i];
        b3_q[i]   <= b2_q[i];
        cr3_q[i]  <= (PROD_W + 1)'(cpa2_q[i]) - (PROD_W + 1)'(cpb2_q[i]);
        aabs4_q[i] <= aabs[i];
        pl4_q[i]  <= PROD_W'(babs[i]) * PROD_W'(dabs[COMP_WIDTH-1:0]);
        ph4_q[i]  <= (PROD_W + 1)'(babs[i]) * (PROD_W + 1)'(dabs[DMAG_W-1:COMP_WIDTH]);
      end
      // cross terms: y*z' - z*y', z*x' - x*z', x*y' - y*x'
      cpa2_q[0] <= PROD_W'(a1_q[1]) * PROD_W'(b1_q[2]);
      cpb2_q[0] <= PROD_W'(a1_q[2]) * PROD_W'(b1_q[1]);
      cpa2_q[1] <= PROD_W'(a1_q[2]) * PROD_W'(b1_q[0]);
      cpb2_q[1] <= PROD_W'(a1_q[0]) * PROD_W'(b1_q[2]);
      cpa2_q[2] <= PROD_W'(a1_q[0]) * PROD_W'(b1_q[1]);
      cpb2_q[2] <= PROD_W'(a1_q[1]) * PROD_W'(b1_q[0]);
      dot3_q  <= DOT_W'(dp2_q[0]) + DOT_W'(dp2_q[1]) + DOT_W'(dp2_q[2]);
      s3_q    <= RAD_W'(sq2_q[0]) + RAD_W'(sq2_q[1]) + RAD_W'(sq2_q[2]);
      u3_q    <= DEN_W'(bb2_q[0]) + DEN_W'(bb2_q[1]) + DEN_W'(bb2_q[2]);
      neg4_q  <= neg_d;
      zin4_q  <= zin_d;
      pre4_q  <= pre_d;
      psat4_q <= psat_d;
      s4_q    <= s3_q;
      u4_q    <= u3_q;
      s5_q    <= s4_q;
      side5_q <= side5_d;
    end
  end

  // root of the sum of squares
  logic              vr;
  logic [ROOT_W-1:0] root;
  sq_side_t          sider;

  vgu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .rad_i   (s5_q),
    .side_i  (side5_q),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (sider)
  );

  dv_side_t         dvs;
  logic [DEN_W-1:0] den;
  always_comb begin
    logic [COMP_WIDTH:0] sv;
    dvs.op      = sider.op;
    dvs.neg     = sider.neg;
    dvs.zin     = sider.zin;
    dvs.pre     = sider.pre;
    dvs.pre_sat = sider.pre_sat;
    sv          = sat_val(NUM_W'(root), 1'b0);
    if (sider.op == OP_MAG || sider.op == OP_DIST) begin
      dvs.pre[3]  = sv[COMP_WIDTH-1:0];
      dvs.pre_sat = sv[COMP_WIDTH];
    end
    den = (sider.op == OP_NORM) ? DEN_W'(root) : sider.den;
  end

  logic                  vd;
  logic [2:0][QUO_W-1:0] quo;
  dv_side_t              sided;

  vgu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vr),
    .num_i   (sider.num),
    .den_i   (den),
    .side_i  (dvs),
    .valid_o (vd),
    .quo_o   (quo),
    .side_o  (sided)
  );

  // final selection and clipping of the quotients
  logic [3:0][COMP_WIDTH-1:0] res_d;
  logic                       sat_d;
  always_comb begin
    logic [COMP_WIDTH:0] sv;
    res_d = sided.pre;
    sat_d = sided.pre_sat;
    sv    = '0;
    if ((sided.op == OP_NORM || sided.op == OP_PROJ) && !sided.zin) begin
      for (int i = 0; i < 3; i++) begin
        sv       = sat_val(NUM_W'(quo[i]), sided.neg[i]);
        res_d[i] = sv[COMP_WIDTH-1:0];
        sat_d    = sat_d | sv[COMP_WIDTH];
      end
    end
  end

  logic [3:0][COMP_WIDTH-1:0] res_q;
  logic                       sat_q;
  logic                       zin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      sat_q <= sat_d;
      zin_q <= sided.zin;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_x_o      = res_q[0];
  assign out_y_o      = res_q[1];
  assign out_z_o      = res_q[2];
  assign out_scalar_o = res_q[3];
  assign saturated_o  = sat_q;
  assign zero_input_o = zin_q;

endmodule
